// ===== sv/sls_pkg.sv =====
package sls_pkg;

	localparam int WORD_W   = 32;
	localparam int MAX_WALK = 8;
	localparam int CFG_W    = 4;

	localparam logic CMD_ARM  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [2:0]         slot;
		logic [31:0]        start_head;
		logic signed [15:0] sweep_acc;
		logic [15:0]        step_limit;
		logic [15:0]        steps_left;
		logic [7:0]         frame_reload;
		logic               bounce_enable;
		logic [31:0]        loop_start;
		logic [31:0]        loop_length;
		logic [31:0]        wrap_threshold;
		logic [31:0]        wrap_span;
	} sls_in_t;

	typedef struct packed {
		logic [2:0]  out_slot;
		logic [31:0] cursor;
		logic        still_active;
		logic        last;
	} sls_out_t;

	// slot state: control part is reset, payload part is not
	typedef struct packed {
		logic        on;
		logic        bounce;
		logic [7:0]  countdown;
	} sls_ctl_t;

	typedef struct packed {
		logic [31:0] head;
		logic [15:0] acc;
		logic [15:0] reload;
		logic [15:0] remaining;
		logic [7:0]  cd_reload;
		logic [31:0] wstart;
		logic [31:0] wlen;
		logic [31:0] thr;
		logic [31:0] span;
	} sls_data_t;

	typedef struct packed {
		sls_ctl_t  ctl;
		sls_data_t data;
	} sls_slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_NXT,
		ST_TOP,
		ST_THR,
		ST_SPAN,
		ST_CMP1,
		ST_CMP2,
		ST_EMIT
	} sls_state_t;

	// operand set for the shared adder
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              sub;
	} sls_alu_op_t;

endpackage

// ===== sv/sls_alu.sv =====
module sls_alu
	import sls_pkg::*;
(
	input  sls_alu_op_t       op,
	output logic [WORD_W-1:0] sum,
	output logic              carry
);

	logic [WORD_W-1:0] b_eff;

	// a - b as a + ~b + 1; carry set means a >= b (unsigned)
	assign b_eff = op.sub ? ~op.b : op.b;
	assign {carry, sum} = {1'b0, op.a} + {1'b0, b_eff} + {{WORD_W{1'b0}}, op.sub};

endmodule

// ===== sv/sls_slot_file.sv =====
module sls_slot_file
	import sls_pkg::*;
#(
	parameter int NUM_SLOTS = 8,
	parameter int IDX_W     = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  sls_slot_t        wdata,
	input  logic [IDX_W-1:0] raddr,
	output sls_slot_t        rdata
);

	sls_ctl_t  ctl_q  [NUM_SLOTS];
	sls_data_t data_q [NUM_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (we) begin
			ctl_q[waddr] <= wdata.ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			data_q[waddr] <= wdata.data;
		end
	end

	assign rdata.ctl  = ctl_q[raddr];
	assign rdata.data = data_q[raddr];

endmodule

// ===== sv/sample_loop_cursor_sweep.sv =====
// Channel   Ports                         Transfer condition
// -------   ---------------------------   -------------------------------
// command   start, busy, item             start && !busy
// result    result_valid, result          result_valid (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// Arm commands take effect in the transfer cycle; busy stays low.
// A frame tick walks min(active_slots, NUM_SLOTS, 8) slots, one at a time,
// through one shared 32-bit adder/comparator. Per slot: load, six adder
// passes and emit when the slot steps; just load and emit when it only counts
// down, is inactive or retires.
// Reset clears the sequencer, active_slots and the per-slot on/bounce/countdown
// bits; slot payload is loaded by arm. The receiver cannot stall results.
module sample_loop_cursor_sweep
	import sls_pkg::*;
#(
	parameter int NUM_SLOTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sls_in_t          item,
	output logic             result_valid,
	output sls_out_t         result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int WALK_MAX = (NUM_SLOTS < MAX_WALK) ? NUM_SLOTS : MAX_WALK;
	localparam logic [CFG_W-1:0] WALK_LIM = CFG_W'(WALK_MAX);

	sls_state_t state_q, state_d;

	logic [CFG_W-1:0] active_slots_q;
	logic [CFG_W-1:0] walk_q;
	logic [CFG_W-1:0] cnt_q;
	logic [CFG_W-1:0] walk_d;

	sls_slot_t         wk_q;       // working copy of the slot being walked
	logic [WORD_W-1:0] nxt_q;      // candidate cursor
	logic [WORD_W-1:0] top_q;      // window top
	logic [WORD_W-1:0] t_q;        // span-adjusted cursor
	logic              above_q;    // cursor above wrap threshold
	logic              pass1_q;

	sls_slot_t         rd_slot;
	sls_slot_t         ld_slot;    // slot after countdown / bounce handling
	logic              ld_step;
	sls_slot_t         arm_slot;
	sls_slot_t         wr_slot;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  rd_idx;

	sls_alu_op_t       alu_op;
	logic [WORD_W-1:0] alu_sum;
	logic              alu_carry;

	logic              accept;
	logic              arm_go;
	logic              tick_go;
	logic              last_slot;
	logic              pass;

	assign accept    = start && !busy;
	assign arm_go    = accept && (item.cmd == CMD_ARM) && (int'(item.slot) < NUM_SLOTS);
	assign walk_d    = (active_slots_q > WALK_LIM) ? WALK_LIM : active_slots_q;
	assign tick_go   = accept && (item.cmd == CMD_TICK) && (walk_d != '0);
	assign last_slot = (cnt_q + CFG_W'(1)) == walk_q;
	assign pass      = pass1_q && alu_carry;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------
	// Slot storage: one write port shared by arm and tick write-back
	// ---------------------------------------------------------------
	always_comb begin
		arm_slot.ctl.on          = 1'b1;
		arm_slot.ctl.bounce      = item.bounce_enable;
		arm_slot.ctl.countdown   = '0;
		arm_slot.data.head       = item.start_head;
		arm_slot.data.acc        = item.sweep_acc;
		arm_slot.data.reload     = item.step_limit;
		arm_slot.data.remaining  = item.steps_left;
		arm_slot.data.cd_reload  = item.frame_reload;
		arm_slot.data.wstart     = item.loop_start;
		arm_slot.data.wlen       = item.loop_length;
		arm_slot.data.thr        = item.wrap_threshold;
		arm_slot.data.span       = item.wrap_span;
	end

	assign rd_idx  = IDX_W'(cnt_q);
	assign wr_en   = arm_go || (state_q == ST_EMIT);
	assign wr_idx  = arm_go ? IDX_W'(item.slot) : rd_idx;
	assign wr_slot = arm_go ? arm_slot : wk_q;

	sls_slot_file #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_file (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_slot),
		.raddr (rd_idx),
		.rdata (rd_slot)
	);

	// ---------------------------------------------------------------
	// Load: countdown, then bounce or retire when out of steps.
	// The slot only moves when steps remain after that.
	// ---------------------------------------------------------------
	always_comb begin
		ld_slot = rd_slot;
		ld_step = 1'b0;
		if (rd_slot.ctl.on) begin
			if (rd_slot.ctl.countdown != '0) begin
				ld_slot.ctl.countdown = rd_slot.ctl.countdown - 8'd1;
			end else begin
				ld_slot.ctl.countdown = rd_slot.data.cd_reload;
				if (rd_slot.data.remaining == '0) begin
					if (rd_slot.ctl.bounce) begin
						ld_slot.data.remaining = rd_slot.data.reload;
						ld_slot.data.acc       = 16'd0 - rd_slot.data.acc;
					end else begin
						ld_slot.ctl.on     = 1'b0;
						ld_slot.ctl.bounce = 1'b0;
					end
				end
				ld_step = (ld_slot.data.remaining != '0);
			end
		end
	end

	// ---------------------------------------------------------------
	// Shared adder / comparator
	// ---------------------------------------------------------------
	sls_alu u_alu (
		.op   (alu_op),
		.sum  (alu_sum),
		.carry(alu_carry)
	);

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ld_step ? ST_NXT : ST_EMIT;
			ST_NXT:  state_d = ST_TOP;
			ST_TOP:  state_d = ST_THR;
			ST_THR:  state_d = ST_SPAN;
			ST_SPAN: state_d = ST_CMP1;
			ST_CMP1: state_d = ST_CMP2;
			ST_CMP2: state_d = ST_EMIT;
			ST_EMIT: state_d = last_slot ? ST_IDLE : ST_LOAD;
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs and adder operands.
	// Above threshold: pass if nxt - span >= base and nxt <= top.
	// Otherwise:       pass if nxt >= base and nxt + span <= top.
	// ---------------------------------------------------------------
	always_comb begin
		busy         = 1'b1;
		result_valid = 1'b0;
		alu_op       = '0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_LOAD: ;
			ST_NXT: begin
				alu_op.a = wk_q.data.head;
				alu_op.b = {{(WORD_W-16){wk_q.data.acc[15]}}, wk_q.data.acc};
			end
			ST_TOP: begin
				alu_op.a = wk_q.data.wstart;
				alu_op.b = wk_q.data.wlen;
			end
			ST_THR: begin
				alu_op.a   = wk_q.data.thr;
				alu_op.b   = wk_q.data.head;
				alu_op.sub = 1'b1;
			end
			ST_SPAN: begin
				alu_op.a   = nxt_q;
				alu_op.b   = wk_q.data.span;
				alu_op.sub = above_q;
			end
			ST_CMP1: begin
				alu_op.a   = above_q ? t_q : nxt_q;
				alu_op.b   = wk_q.data.wstart;
				alu_op.sub = 1'b1;
			end
			ST_CMP2: begin
				alu_op.a   = top_q;
				alu_op.b   = above_q ? nxt_q : t_q;
				alu_op.sub = 1'b1;
			end
			ST_EMIT: result_valid = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	assign result.out_slot     = 3'(cnt_q);
	assign result.cursor       = wk_q.data.head;
	assign result.still_active = wk_q.ctl.on;
	assign result.last         = last_slot;

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_slots_q <= '0;
			walk_q         <= '0;
			cnt_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				active_slots_q <= cfg_data;
			end
			if (tick_go) begin
				walk_q <= walk_d;
				cnt_q  <= '0;
			end else if (state_q == ST_EMIT) begin
				cnt_q <= cnt_q + CFG_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Working registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: wk_q    <= ld_slot;
			ST_NXT:  nxt_q   <= alu_sum;
			ST_TOP:  top_q   <= alu_sum;
			ST_THR:  above_q <= !alu_carry;   // borrow on thr - cur
			ST_SPAN: t_q     <= alu_sum;
			ST_CMP1: pass1_q <= alu_carry;
			ST_CMP2: begin
				if (pass) begin
					wk_q.data.head      <= nxt_q;
					wk_q.data.remaining <= wk_q.data.remaining - 16'd1;
				end else begin
					wk_q.data.reload    <= wk_q.data.reload - wk_q.data.remaining;
					wk_q.data.remaining <= '0;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a walk");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |=> !busy)
		else $error("walk continues after last result");

	a_results_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> !result_valid)
		else $error("results back to back within a walk");

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_TICK && active_slots_q != '0) |=> busy)
		else $error("tick did not start a walk");

endmodule
